>>> src/sah_pkg.sv
// Shared types, codes and field widths of the snapshot array history block.
`timescale 1ns / 1ps

package sah_pkg;

    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 6;
    localparam int VALUE_W   = 31;
    localparam int QUERY_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 56;
    localparam int INDEX_SPAN = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET  = 2'd0,
        CMD_SNAP = 2'd1,
        CMD_GET  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_DROP = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    typedef struct packed {
        logic accept;
        logic snap_do;
        logic set_drop;
        logic cnt_rd;
        logic cnt_latch;
        logic last_rd;
        logic ent_write;
        logic append;
        logic srch_rd;
        logic srch_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic pos_ok;
        logic n_zero;
        logic id_match;
        logic hist_full;
        logic search_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

>>> src/sah_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module sah_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/sah_ctrl.sv
// Controller state machine that sequences set, snap and get commands.
`timescale 1ns / 1ps

module sah_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  sah_pkg::ctrl_sts_t sts,
    output sah_pkg::ctrl_cmd_t cmd
);

    import sah_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE        = 9'b000000001,
        S_DECODE      = 9'b000000010,
        S_CNT_WAIT    = 9'b000000100,
        S_APPEND      = 9'b000001000,
        S_LAST_RD     = 9'b000010000,
        S_LAST_WAIT   = 9'b000100000,
        S_SEARCH      = 9'b001000000,
        S_SEARCH_WAIT = 9'b010000000,
        S_DONE        = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (sts.cmd)
                    CMD_SNAP: begin
                        cmd.snap_do = 1'b1;
                        state_next  = S_DONE;
                    end
                    CMD_SET, CMD_GET: begin
                        if (!sts.pos_ok) begin
                            cmd.set_drop = (sts.cmd == CMD_SET);
                            state_next   = S_DONE;
                        end else begin
                            cmd.cnt_rd = 1'b1;
                            state_next = S_CNT_WAIT;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_CNT_WAIT: begin
                cmd.cnt_latch = 1'b1;
                if (sts.cmd == CMD_GET) begin
                    state_next = S_SEARCH;
                end else if (sts.n_zero) begin
                    state_next = S_APPEND;
                end else begin
                    state_next = S_LAST_RD;
                end
            end
            S_APPEND: begin
                cmd.ent_write = 1'b1;
                cmd.append    = 1'b1;
                state_next    = S_DONE;
            end
            S_LAST_RD: begin
                cmd.last_rd = 1'b1;
                state_next  = S_LAST_WAIT;
            end
            S_LAST_WAIT: begin
                priority if (sts.id_match) begin
                    cmd.ent_write = 1'b1;
                end else if (sts.hist_full) begin
                    cmd.set_drop = 1'b1;
                end else begin
                    cmd.ent_write = 1'b1;
                    cmd.append    = 1'b1;
                end
                state_next = S_DONE;
            end
            S_SEARCH: begin
                if (sts.search_done) begin
                    state_next = S_DONE;
                end else begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SEARCH_WAIT;
                end
            end
            S_SEARCH_WAIT: begin
                cmd.srch_step = 1'b1;
                state_next    = S_SEARCH;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/sah_dp.sv
// Datapath: command registers, snapshot counter, history memories and result register.
`timescale 1ns / 1ps

module sah_dp #(
    parameter int LENGTH        = 64,
    parameter int HISTORY_DEPTH = 16,
    parameter int SNAP_BITS     = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  sah_pkg::cmd_t                   in_cmd,
    input  logic [sah_pkg::INDEX_W-1:0]     in_index,
    input  logic [sah_pkg::VALUE_W-1:0]     in_value,
    input  logic [sah_pkg::QUERY_W-1:0]     in_query_snapshot,
    input  sah_pkg::ctrl_cmd_t              cmd,
    output sah_pkg::ctrl_sts_t              sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sah_pkg::M_TDATA_W-1:0]   m_tdata
);

    import sah_pkg::*;

    localparam int POS_DEPTH = (LENGTH < INDEX_SPAN) ? LENGTH : INDEX_SPAN;
    localparam int POS_W     = (POS_DEPTH > 1) ? $clog2(POS_DEPTH) : 1;
    localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int HIST_N    = POS_DEPTH * HISTORY_DEPTH;
    localparam int HA_W      = (HIST_N > 1) ? $clog2(HIST_N) : 1;
    localparam int ENT_W     = SNAP_BITS + VALUE_W;
    localparam int CMP_W     = (SNAP_BITS > QUERY_W) ? SNAP_BITS : QUERY_W;
    localparam int PAD_W     = M_TDATA_W - VALUE_W - QUERY_W - STATUS_W;

    cmd_t                   cmd_reg;
    logic [INDEX_W-1:0]     index_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic [QUERY_W-1:0]     query_reg;
    logic [SNAP_BITS-1:0]   cur_reg;
    logic [CNT_W-1:0]       n_reg;
    logic [CNT_W-1:0]       lo_reg;
    logic [CNT_W-1:0]       hi_reg;
    logic [CNT_W-1:0]       mid_reg;
    logic [VALUE_W-1:0]     best_reg;
    logic [QUERY_W-1:0]     ts_reg;
    status_t                st_reg;
    logic                   cnt_vld_q_reg;
    logic [POS_DEPTH-1:0]   cnt_valid_reg;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    logic [POS_W-1:0]       pos;
    logic [CNT_W-1:0]       cnt_rd_data;
    logic [CNT_W-1:0]       n_live;
    logic [CNT_W:0]         mid_sum;
    logic [CNT_W-1:0]       mid;
    logic [CNT_W-1:0]       slot;
    logic [HA_W-1:0]        base;
    logic                   hist_rd_en;
    logic [HA_W-1:0]        hist_rd_addr;
    logic [HA_W-1:0]        hist_wr_addr;
    logic [ENT_W-1:0]       hist_rd_data;
    logic [SNAP_BITS-1:0]   rd_id;
    logic [VALUE_W-1:0]     rd_val;
    logic                   id_le_query;

    assign pos     = POS_W'(index_reg);
    assign n_live  = cnt_vld_q_reg ? cnt_rd_data : '0;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign slot    = cmd.append ? n_reg : (n_reg - CNT_W'(1));
    assign base    = HA_W'(pos) * HA_W'(HISTORY_DEPTH);
    assign rd_id   = hist_rd_data[ENT_W-1:VALUE_W];
    assign rd_val  = hist_rd_data[VALUE_W-1:0];
    assign id_le_query = CMP_W'(rd_id) <= CMP_W'(query_reg);

    assign hist_rd_en   = cmd.last_rd | cmd.srch_rd;
    assign hist_rd_addr = base + (cmd.srch_rd ? HA_W'(mid) : HA_W'(n_reg - CNT_W'(1)));
    assign hist_wr_addr = base + HA_W'(slot);

    assign sts.cmd         = cmd_reg;
    assign sts.pos_ok      = {1'b0, index_reg} < (INDEX_W + 1)'(POS_DEPTH);
    assign sts.n_zero      = (n_live == '0);
    assign sts.id_match    = (rd_id == cur_reg);
    assign sts.hist_full   = (n_reg >= CNT_W'(HISTORY_DEPTH));
    assign sts.search_done = (lo_reg == hi_reg);
    assign sts.out_free    = !m_tvalid_reg || m_tready;

    sah_ram #(
        .WIDTH (CNT_W),
        .DEPTH (POS_DEPTH)
    ) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (cmd.append),
        .wr_addr (pos),
        .wr_data (n_reg + CNT_W'(1)),
        .rd_en   (cmd.cnt_rd),
        .rd_addr (pos),
        .rd_data (cnt_rd_data)
    );

    sah_ram #(
        .WIDTH (ENT_W),
        .DEPTH (HIST_N)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (cmd.ent_write),
        .wr_addr (hist_wr_addr),
        .wr_data ({cur_reg, value_reg}),
        .rd_en   (hist_rd_en),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg       <= '0;
            cnt_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cmd.snap_do && (cur_reg != '1)) begin
                cur_reg <= cur_reg + SNAP_BITS'(1);
            end
            if (cmd.append) begin
                cnt_valid_reg[pos] <= 1'b1;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg   <= in_cmd;
            index_reg <= in_index;
            value_reg <= in_value;
            query_reg <= in_query_snapshot;
            best_reg  <= '0;
            ts_reg    <= '0;
            st_reg    <= ST_OK;
        end
        if (cmd.snap_do) begin
            ts_reg <= QUERY_W'(cur_reg);
            if (cur_reg == '1) begin
                st_reg <= ST_SAT;
            end
        end
        if (cmd.set_drop) begin
            st_reg <= ST_DROP;
        end
        if (cmd.cnt_rd) begin
            cnt_vld_q_reg <= cnt_valid_reg[pos];
        end
        if (cmd.cnt_latch) begin
            n_reg  <= n_live;
            lo_reg <= '0;
            hi_reg <= n_live;
        end
        if (cmd.srch_rd) begin
            mid_reg <= mid;
        end
        if (cmd.srch_step) begin
            if (id_le_query) begin
                lo_reg   <= mid_reg + CNT_W'(1);
                best_reg <= rd_val;
            end else begin
                hi_reg <= mid_reg;
            end
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, st_reg, ts_reg, best_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> src/snapshot_array_history_core.sv
// Top level of the snapshot array history block: stream ports, controller and datapath.
//
//  Channel | Ports                               | Contents
//  --------+-------------------------------------+-----------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser   | command: tuser cmd, tdata index/value/query
//  result  | m_tvalid m_tready m_tdata           | read_value, taken_snapshot, status
//
// A snap, an unknown command or an out-of-range position goes from decode to the result.
// A set reads the position's entry count and appends at once into an empty history; otherwise
// it first reads the newest entry. A get runs a binary search over the n stored entries, in
// which each binary-search step is one registered read of the history memory.
// Reset clears the snapshot counter and the per-position valid bits; no clearing pass is run.
// A new command is taken while an earlier result still waits in the output register.
`timescale 1ns / 1ps

module snapshot_array_history_core #(
    parameter int LENGTH        = 64,
    parameter int HISTORY_DEPTH = 16,
    parameter int SNAP_BITS     = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // index [5:0], value [36:6], query_snapshot [52:37], zero pad above
    input  logic [sah_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd [1:0]
    input  logic [sah_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_value [30:0], taken_snapshot [46:31], status [48:47], zero pad above
    output logic [sah_pkg::M_TDATA_W-1:0] m_tdata
);

    import sah_pkg::*;

    localparam int IDX_LO = 0;
    localparam int VAL_LO = IDX_LO + INDEX_W;
    localparam int QRY_LO = VAL_LO + VALUE_W;

    ctrl_cmd_t ctrl_cmd;
    ctrl_sts_t ctrl_sts;

    sah_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (ctrl_sts),
        .cmd      (ctrl_cmd)
    );

    sah_dp #(
        .LENGTH        (LENGTH),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SNAP_BITS     (SNAP_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_cmd            (cmd_t'(s_tuser)),
        .in_index          (s_tdata[VAL_LO-1:IDX_LO]),
        .in_value          (s_tdata[QRY_LO-1:VAL_LO]),
        .in_query_snapshot (s_tdata[QRY_LO+QUERY_W-1:QRY_LO]),
        .cmd               (ctrl_cmd),
        .sts               (ctrl_sts),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata)
    );

endmodule
